/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every rising clock edge outside reset.
`define ASSERT_NOW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that trig at one edge is followed by resp at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, trig, resp, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (resp)) \
        else $error(msg);

`endif

/* rtl/core/frf_pkg.sv */
// Shared constants and types of the fixed-point ring FIR filter.
package frf_pkg;

    localparam int TAPS_DEFAULT = 101;
    localparam int DATA_W       = 32;
    localparam int TAP_INDEX_W  = 7;
    localparam int FRAC_W       = 5;
    localparam int ACC_W        = 64;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd15;

    // Item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef struct packed {
        logic start;   // clear the accumulator for a new sample
        logic valid;   // operand pair present this cycle
        logic last;    // operand pair belongs to the last tap
    } mac_ctrl_t;

    typedef struct packed {
        logic              done;    // accumulator holds the final sum
        logic [DATA_W-1:0] result;  // shifted and truncated sum
    } mac_stat_t;

endpackage

/* rtl/core/fir_ring_fixed_point_top.sv */
// Top level of the fixed-point ring FIR filter: sequencer, stores and output register.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------
//  in      | in_valid / in_stall      | mode, tap_index, data
//  out     | out_valid / out_stall    | filtered
//  cfg     | cfg_valid / cfg_ready    | cfg_data (frac_bits)
//
// After a coefficient transfer the input stays ready; the next item is taken in the following cycle.
// A sample is walked tap by tap: one read of each store per tap through the shared
// multiply-accumulate, plus read, product, sum and output stages.
// After reset the delay line is zeroed slot by slot while in_stall stays high.
// A finished result waits in the output register; a new item is taken meanwhile,
// and a later sample result waits in S_FINISH, with in_stall high, until the register frees.
module fir_ring_fixed_point_top #(
    parameter int TAPS = frf_pkg::TAPS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [frf_pkg::TAP_INDEX_W-1:0]   tap_index,
    input  logic signed [frf_pkg::DATA_W-1:0] data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [frf_pkg::DATA_W-1:0] filtered,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [frf_pkg::FRAC_W-1:0]        cfg_data
);
    import frf_pkg::*;

    localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]        state_reg,    state_next;
    logic [TAP_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [TAP_W-1:0]  wpos_reg,     wpos_next;
    logic [TAP_W-1:0]  pos_reg,      pos_next;
    logic [TAP_W-1:0]  k_reg,        k_next;
    logic              rd_vld_reg,   rd_vld_next;
    logic              rd_last_reg,  rd_last_next;
    logic [FRAC_W-1:0] frac_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] filtered_reg;

    logic              in_accept;
    logic              sample_accept;
    logic              coef_accept;
    logic              out_free;
    logic              load_out;

    logic              dl_we;
    logic [TAP_W-1:0]  dl_waddr;
    logic [DATA_W-1:0] dl_wdata;
    logic [DATA_W-1:0] dl_rdata;
    logic              cf_we;
    logic [DATA_W-1:0] cf_rdata;

    mac_ctrl_t         mac_ctrl;
    mac_stat_t         mac_stat;

    assign in_accept     = in_valid && (state_reg == S_IDLE);
    assign sample_accept = in_accept && (mode == MODE_SAMPLE);
    assign coef_accept   = in_accept && (mode == MODE_COEF);
    assign out_free      = !out_valid_reg || !out_stall;
    assign load_out      = (state_reg == S_FINISH) && out_free;

    // Delay line: zero sweep after reset, then one sample write per sample transfer
    assign dl_we    = (state_reg == S_CLEAR) || sample_accept;
    assign dl_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : wpos_reg;
    assign dl_wdata = (state_reg == S_CLEAR) ? '0 : DATA_W'(data);

    // Drop coefficient writes beyond the last tap
    assign cf_we = coef_accept && (int'(tap_index) < TAPS);

    frf_ram #(
        .DEPTH (TAPS),
        .WIDTH (DATA_W),
        .ADDR_W(TAP_W)
    ) u_delay_ram (
        .clk  (clk),
        .we   (dl_we),
        .waddr(dl_waddr),
        .wdata(dl_wdata),
        .raddr(pos_reg),
        .rdata(dl_rdata)
    );

    frf_ram #(
        .DEPTH (TAPS),
        .WIDTH (DATA_W),
        .ADDR_W(TAP_W)
    ) u_coef_ram (
        .clk  (clk),
        .we   (cf_we),
        .waddr(TAP_W'(tap_index)),
        .wdata(DATA_W'(data)),
        .raddr(k_reg),
        .rdata(cf_rdata)
    );

    assign mac_ctrl.start = sample_accept;
    assign mac_ctrl.valid = rd_vld_reg;
    assign mac_ctrl.last  = rd_last_reg;

    frf_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .sample   (dl_rdata),
        .coef     (cf_rdata),
        .frac_bits(frac_reg),
        .stat     (mac_stat)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        wpos_next     = wpos_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        rd_vld_next   = 1'b0;
        rd_last_next  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_TAP)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sample_accept)
                begin
                    // walk starts at the slot just written, tap 0
                    pos_next   = wpos_reg;
                    k_next     = '0;
                    wpos_next  = (wpos_reg == LAST_TAP) ? '0 : wpos_reg + 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                rd_vld_next  = 1'b1;
                rd_last_next = (k_reg == LAST_TAP);
                k_next       = k_reg + 1'b1;
                pos_next     = (pos_reg == '0) ? LAST_TAP : pos_reg - 1'b1;
                if (k_reg == LAST_TAP)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (mac_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            wpos_reg      <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            frac_reg      <= FRAC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            wpos_reg      <= wpos_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            rd_vld_reg    <= rd_vld_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                frac_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            filtered_reg <= mac_stat.result;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign filtered  = $signed(filtered_reg);

endmodule

/* rtl/core/frf_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module frf_ram #(
    parameter int DEPTH  = frf_pkg::TAPS_DEFAULT,
    parameter int WIDTH  = frf_pkg::DATA_W,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/frf_mac.sv */
// Registered signed multiply, 64-bit wrapping accumulate and output shift.
module frf_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  frf_pkg::mac_ctrl_t            ctrl,
    input  logic [frf_pkg::DATA_W-1:0]    sample,
    input  logic [frf_pkg::DATA_W-1:0]    coef,
    input  logic [frf_pkg::FRAC_W-1:0]    frac_bits,
    output frf_pkg::mac_stat_t            stat
);
    import frf_pkg::*;

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] shifted;
    logic                    prod_vld_reg;
    logic                    prod_last_reg;
    logic                    done_reg;

    assign prod_next = $signed(sample) * $signed(coef);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_vld_reg  <= ctrl.valid;
            prod_last_reg <= ctrl.valid && ctrl.last;
            done_reg      <= prod_vld_reg && prod_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.start)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            // wraps modulo 2^64
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign shifted     = acc_reg >>> frac_bits;
    assign stat.done   = done_reg;
    assign stat.result = shifted[DATA_W-1:0];

endmodule

/* rtl/core/frf_checker.sv */
// Port-level checker for the fixed-point ring FIR filter, with its bind.
`include "assert_macros.svh"

module frf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            mode,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [frf_pkg::DATA_W-1:0]      filtered,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);
    import frf_pkg::*;

    logic sample_xfer;
    logic coef_xfer;
    logic out_held;

    assign sample_xfer = in_valid && !in_stall && (mode == MODE_SAMPLE);
    assign coef_xfer   = in_valid && !in_stall && (mode == MODE_COEF);
    assign out_held    = out_valid && out_stall;

    // a sample transfer is followed by a busy input side as the tap walk begins
    `ASSERT_NEXT(a_sample_busy, clk, rst_n, sample_xfer, in_stall, "input free after sample")

    // a coefficient write leaves the input ready for the next item
    `ASSERT_NEXT(a_coef_ready, clk, rst_n, coef_xfer, !in_stall, "input busy after coefficient")

    // the configuration register is always writable
    `ASSERT_NOW(a_cfg_ready, clk, rst_n, !cfg_valid || cfg_ready, "configuration write refused")

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(filtered), "result changed")

endmodule

bind fir_ring_fixed_point_top frf_checker u_frf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered (filtered),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);

/* tb/fir_ring_fixed_point_top_tb.sv */
// Self-checking testbench for the fixed-point ring FIR filter top level.
module fir_ring_fixed_point_top_tb;
    import frf_pkg::*;

    localparam int TAPS = TAPS_DEFAULT;

    typedef struct packed {
        logic                   mode;
        logic [TAP_INDEX_W-1:0] tap_index;
        logic [DATA_W-1:0]      data;
    } fir_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     mode = MODE_SAMPLE;
    logic [TAP_INDEX_W-1:0]   tap_index = '0;
    logic signed [DATA_W-1:0] data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] filtered;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [FRAC_W-1:0]        cfg_data = '0;

    // Predictor state: delay line, taps, ring slot and shift
    logic signed [DATA_W-1:0] sample_ring [TAPS];
    logic signed [DATA_W-1:0] tap_values [TAPS];
    int                       ring_slot = 0;
    logic [FRAC_W-1:0]        frac_shift = FRAC_RESET;

    fir_item_t                pending_items [$];
    logic signed [DATA_W-1:0] expected_outputs [$];
    fir_item_t                next_item;

    int in_gap = 0;
    int stall_left = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;
    int errors = 0;
    int outputs_checked = 0;
    int samples_sent = 0;
    int coefs_sent = 0;
    int cfg_writes = 0;

    fir_ring_fixed_point_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .tap_index (tap_index),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Push one sample through the delay line and return the filter output.
    function automatic logic signed [DATA_W-1:0] filter_sample(
        input logic signed [DATA_W-1:0] x
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shifted;
        int                      slot;
        sample_ring[ring_slot] = x;
        slot = ring_slot;
        ring_slot = (ring_slot == TAPS - 1) ? 0 : ring_slot + 1;
        acc = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            acc = acc + longint'(sample_ring[slot]) * longint'(tap_values[k]);
            slot = (slot == 0) ? TAPS - 1 : slot - 1;
        end
        shifted = acc >>> frac_shift;
        return shifted[DATA_W-1:0];
    endfunction

    function automatic int gap_length(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    // 0: full range, 1: small signed, 2: extreme corners
    function automatic logic [DATA_W-1:0] random_word(input int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 65535) - 32768;
            default:
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
        endcase
    endfunction

    task automatic queue_coef(input int idx, input logic [DATA_W-1:0] value);
        pending_items.push_back('{MODE_COEF, idx[TAP_INDEX_W-1:0], value});
    endtask

    task automatic queue_sample(input logic [DATA_W-1:0] value);
        pending_items.push_back('{MODE_SAMPLE, TAP_INDEX_W'($urandom), value});
    endtask

    // Block until every item is sent and every output is back, then let the pipe drain.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_outputs.size() != 0);
        repeat (TAPS + 20) @(negedge clk);
    endtask

    task automatic write_frac(input logic [FRAC_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        frac_shift = value;
        cfg_writes++;
    endtask

    // Driver: hold a stalled transfer, otherwise feed the next pending item after a gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            mode      <= MODE_SAMPLE;
            tap_index <= '0;
            data      <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_COEF)
                begin
                    if (tap_index < TAPS)
                        tap_values[tap_index] = data;
                    coefs_sent++;
                end
                else
                begin
                    expected_outputs.push_back(filter_sample(data));
                    samples_sent++;
                end
            end
            if ($urandom_range(0, 127) == 0)
                in_steady = !in_steady;
            if (in_valid && in_stall)
            begin
                // hold the payload
            end
            else if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                mode      <= next_item.mode;
                tap_index <= next_item.tap_index;
                data      <= next_item.data;
                in_valid  <= 1'b1;
                in_gap    = gap_length(in_steady);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each output transfer against the oldest expectation and drive random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $display("%0t: unexpected output, expected none, actual %h",
                             $time, filtered);
                    errors++;
                end
                else
                begin
                    if (filtered !== expected_outputs[0])
                    begin
                        $display("%0t: filtered mismatch, expected %h, actual %h",
                                 $time, expected_outputs[0], filtered);
                        errors++;
                    end
                    void'(expected_outputs.pop_front());
                    outputs_checked++;
                end
            end
            if ($urandom_range(0, 127) == 0)
                out_steady = !out_steady;
            if (stall_left != 0)
                stall_left--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = gap_length(out_steady);
            out_stall <= (stall_left != 0);
        end
    end

    initial
    begin
        int                phase_frac;
        int                style;
        int                idx;
        logic [FRAC_W-1:0] frac_list [8];

        for (int k = 0; k < TAPS; k++)
        begin
            sample_ring[k] = '0;
            tap_values[k]  = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset shift: most negative taps, corner samples,
        // accumulator wrap, ignored writes past the last tap, tap rewrites.
        for (int k = 0; k < TAPS; k++)
            queue_coef(k, 32'h8000_0000);
        repeat (4) queue_sample(32'h8000_0000);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h0000_0000);
        queue_sample(32'hFFFF_FFFF);
        queue_sample(32'h0000_0001);
        queue_coef(TAPS, 32'h1234_5678);
        queue_coef(127, 32'hFFFF_FFFF);
        queue_coef(0, 32'h7FFF_FFFF);
        queue_coef(TAPS - 1, 32'h0000_0001);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h8000_0000);
        queue_sample(32'h5555_AAAA);
        wait_idle();

        frac_list[0] = 5'd0;
        frac_list[1] = 5'd31;
        frac_list[2] = 5'd30;
        for (int p = 3; p < 8; p++)
            frac_list[p] = FRAC_W'($urandom_range(0, 31));

        for (int p = 0; p < 8; p++)
        begin
            phase_frac = frac_list[p];
            write_frac(phase_frac[FRAC_W-1:0]);
            style = $urandom_range(0, 2);
            for (int k = 0; k < TAPS; k++)
                queue_coef(k, random_word(style));
            for (int n = 0; n < 66; n++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    idx = $urandom_range(0, 127);
                    queue_coef(idx, random_word($urandom_range(0, 2)));
                end
                else
                    queue_sample(random_word($urandom_range(0, 2)));
            end
            wait_idle();
        end

        $display("Covered %0d samples and %0d coefficient transfers over %0d shift writes",
                 samples_sent, coefs_sent, cfg_writes);
        $display("including shifts 0, 30 and 31; %0d filter outputs compared, %0d errors",
                 outputs_checked, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/frf_pkg.sv
rtl/core/frf_ram.sv
rtl/core/frf_mac.sv
rtl/core/fir_ring_fixed_point_top.sv
rtl/core/frf_checker.sv
tb/fir_ring_fixed_point_top_tb.sv
